// ===== design/pcx_rld_pkg.sv =====
// shared constants and types for the pcx run-length line decoder
package pcx_rld_pkg;

    // clamps on the decoded image size
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int WIDTH_W  = 11;
    localparam int LINE_W   = 12;
    localparam int HEIGHT_W = 11;
    localparam int PLANE_W  = 3;
    localparam int COL_W    = 12;
    localparam int ROW_W    = 11;
    localparam int RUN_W    = 6;
    localparam int POS_W    = 10;

    // run header marking
    localparam logic [BYTE_W-1:0] RUN_MARK = 8'hC0;
    localparam logic [BYTE_W-1:0] RUN_MASK = 8'h3F;

    // configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_LINE_BYTES   = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2,
        REG_PLANE_COUNT  = 2'd3
    } reg_index_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } dec_state_t;

endpackage

// ===== design/pcx_rle_line_decoder.sv =====
// pcx run-length line decoder with apb configuration and stream ports
//
// Decodes an 8-bit PCX run-length stream, one code byte per input request.
// A byte with both top bits set is a run header: its low six bits give a
// repeat count for the following byte. Any other byte is a single literal
// pixel. Each pixel leaves on the output stream with its column and row;
// pixels past the visible width (row padding) are dropped, a row closes
// once the padded row length max(image_width, line_bytes) is reached, and
// bytes after the last row are ignored until a request with start_image
// set. With plane_count other than one nothing is emitted. Flow: a run
// header, the byte after an empty run header or an ignored byte is absorbed
// in its accept cycle; a byte that starts an expansion is accepted and then
// stepped through the positions it covers up to the row end (dropped
// padding positions included) on the single column counter and compare,
// one position per cycle while the output side does not stall. Input is not
// ready while a byte is being expanded. The user must write configuration
// only while the block is idle; the block itself does not enforce it.
module pcx_rle_line_decoder
    import pcx_rld_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // apb configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] code_byte
    input  logic                  s_axis_tuser,   // [0] start_image
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,   // [7:0] pixel_value, [17:8] column,
                                                  // [27:18] row, [31:28] zero
    output logic                  m_axis_tlast    // last_of_byte
);

    // configuration registers
    logic [WIDTH_W-1:0]  image_width_reg;
    logic [LINE_W-1:0]   line_bytes_reg;
    logic [HEIGHT_W-1:0] image_height_reg;
    logic [PLANE_W-1:0]  plane_count_reg;

    // sequencer and position state
    dec_state_t          state_reg, state_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic                pend_reg, pend_next;
    logic [RUN_W-1:0]    len_reg, len_next;
    logic [RUN_W-1:0]    cnt_reg, cnt_next;
    logic [BYTE_W-1:0]   byte_reg, byte_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]   out_pix_reg, out_pix_next;
    logic [POS_W-1:0]    out_col_reg, out_col_next;
    logic [POS_W-1:0]    out_row_reg, out_row_next;
    logic                out_last_reg, out_last_next;

    // derived geometry
    logic [WIDTH_W-1:0]  visible;
    logic [HEIGHT_W-1:0] height;
    logic [LINE_W-1:0]   padded_raw;
    logic [LINE_W-1:0]   padded;

    // accept path
    logic                cfg_write;
    logic                accept;
    logic [COL_W-1:0]    col_e;
    logic [ROW_W-1:0]    row_e;
    logic                pend_e;
    logic [RUN_W-1:0]    len_e;
    logic                start_loop;
    logic [RUN_W-1:0]    start_cnt;

    // iteration path
    logic                step;
    logic [COL_W-1:0]    col_inc;
    logic                row_end;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    // clamp width and height, padded length is at least one
    assign visible    = (32'(image_width_reg) < MAX_WIDTH)
                        ? image_width_reg : WIDTH_W'(MAX_WIDTH);
    assign height     = (32'(image_height_reg) < MAX_HEIGHT)
                        ? image_height_reg : HEIGHT_W'(MAX_HEIGHT);
    assign padded_raw = (LINE_W'(image_width_reg) > line_bytes_reg)
                        ? LINE_W'(image_width_reg) : line_bytes_reg;
    assign padded     = (padded_raw == '0) ? LINE_W'(1) : padded_raw;

    // config register read back
    always_comb
    begin
        case (reg_index_t'(paddr[3:2]))
            REG_IMAGE_WIDTH:  prdata = CFG_DATA_W'(image_width_reg);
            REG_LINE_BYTES:   prdata = CFG_DATA_W'(line_bytes_reg);
            REG_IMAGE_HEIGHT: prdata = CFG_DATA_W'(image_height_reg);
            REG_PLANE_COUNT:  prdata = CFG_DATA_W'(plane_count_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_W'(1);
            line_bytes_reg   <= LINE_W'(1);
            image_height_reg <= HEIGHT_W'(1);
            plane_count_reg  <= PLANE_W'(1);
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(paddr[3:2]))
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[WIDTH_W-1:0];
                REG_LINE_BYTES:   line_bytes_reg   <= pwdata[LINE_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[HEIGHT_W-1:0];
                REG_PLANE_COUNT:  plane_count_reg  <= pwdata[PLANE_W-1:0];
                default:          ;
            endcase
        end
    end

    // input is taken only when the sequencer is idle
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid & s_axis_tready;

    // start_image clears the position before the byte is looked at
    assign col_e  = s_axis_tuser ? '0 : col_reg;
    assign row_e  = s_axis_tuser ? '0 : row_reg;
    assign pend_e = s_axis_tuser ? 1'b0 : pend_reg;
    assign len_e  = s_axis_tuser ? '0 : len_reg;

    // one pixel position per cycle, only when the output slot is free
    assign step    = (state_reg == ST_RUN) & (~out_valid_reg | m_axis_tready);
    assign col_inc = col_reg + COL_W'(1);
    assign row_end = (col_inc >= padded);

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        pend_next      = pend_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        byte_next      = byte_reg;
        out_valid_next = out_valid_reg & ~m_axis_tready;
        out_pix_next   = out_pix_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_last_next  = out_last_reg;
        start_loop     = 1'b0;
        start_cnt      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    col_next  = col_e;
                    row_next  = row_e;
                    pend_next = pend_e;
                    len_next  = len_e;
                    // unsupported plane layouts and finished images drop the byte
                    if ((plane_count_reg == PLANE_W'(1)) && (row_e < ROW_W'(height)))
                    begin
                        if (pend_e)
                        begin
                            start_loop = 1'b1;
                            start_cnt  = len_e;
                            pend_next  = 1'b0;
                            len_next   = '0;
                        end
                        else if ((s_axis_tdata & RUN_MARK) == RUN_MARK)
                        begin
                            pend_next = 1'b1;
                            len_next  = RUN_W'(s_axis_tdata & RUN_MASK);
                        end
                        else
                        begin
                            start_loop = 1'b1;
                            start_cnt  = RUN_W'(1);
                        end
                    end
                    if (start_loop)
                    begin
                        if (col_e >= padded)
                        begin
                            // row already full after a geometry change
                            col_next = '0;
                            row_next = row_e + ROW_W'(1);
                        end
                        else if (start_cnt != '0)
                        begin
                            state_next = ST_RUN;
                            cnt_next   = start_cnt;
                            byte_next  = s_axis_tdata;
                        end
                    end
                end
            end

            ST_RUN:
            begin
                if (step)
                begin
                    if (col_reg < COL_W'(visible))
                    begin
                        out_valid_next = 1'b1;
                        out_pix_next   = byte_reg;
                        out_col_next   = col_reg[POS_W-1:0];
                        out_row_next   = row_reg[POS_W-1:0];
                        // later positions of this byte are all padding or absent
                        out_last_next  = (cnt_reg == RUN_W'(1))
                                         || (col_inc >= COL_W'(visible));
                    end
                    cnt_next = cnt_reg - RUN_W'(1);
                    if (row_end)
                    begin
                        col_next   = '0;
                        row_next   = row_reg + ROW_W'(1);
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        col_next = col_inc;
                        if (cnt_reg == RUN_W'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            pend_reg      <= 1'b0;
            len_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            pend_reg      <= pend_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        out_pix_reg  <= out_pix_next;
        out_col_reg  <= out_col_next;
        out_row_reg  <= out_row_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_row_reg, out_col_reg, out_pix_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule
